[rtl/hpde_pkg.sv]
// ----------------------------------------------------------------------------
// Hyperbola evaluator package
// Shared types, constants and elaboration-time helpers for the hyperbola
// point and derivative evaluator.
// ----------------------------------------------------------------------------
package hpde_pkg;

  // Default number of CORDIC cells in the exponential chain.
  localparam int CordicIterDefault = 28;

  // ln(2) in Q56, the fixed-point one in Q60 and 1/ln(2) in Q16.
  localparam logic [55:0] LN2_Q56     = 56'hB17217F7D1CF7A;
  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [16:0] INV_LN2_Q16 = 17'd94548;

  // Configuration register indexes.
  localparam logic [2:0] REG_CENTER_XY = 3'd0;
  localparam logic [2:0] REG_CENTER_Z  = 3'd1;
  localparam logic [2:0] REG_MAJOR_X   = 3'd2;
  localparam logic [2:0] REG_MAJOR_Y   = 3'd3;
  localparam logic [2:0] REG_MAJOR_Z   = 3'd4;
  localparam logic [2:0] REG_MINOR_X   = 3'd5;
  localparam logic [2:0] REG_MINOR_Y   = 3'd6;
  localparam logic [2:0] REG_MINOR_Z   = 3'd7;

  // One request: curve parameter and derivative order.
  typedef struct packed {
    logic signed [30:0] param_u;
    logic [5:0]         deriv_order;
  } hpde_req_t;

  // One result: four 3-vectors in Q32.32.
  typedef struct packed {
    logic signed [63:0] point_x;
    logic signed [63:0] point_y;
    logic signed [63:0] point_z;
    logic signed [63:0] first_deriv_x;
    logic signed [63:0] first_deriv_y;
    logic signed [63:0] first_deriv_z;
    logic signed [63:0] second_deriv_x;
    logic signed [63:0] second_deriv_y;
    logic signed [63:0] second_deriv_z;
    logic signed [63:0] nth_deriv_x;
    logic signed [63:0] nth_deriv_y;
    logic signed [63:0] nth_deriv_z;
  } hpde_res_t;

  // Data handed from cell to cell: two exponential lanes, one for e^r and
  // one for e^(ln2 - r), plus the binary exponent and the order parity.
  typedef struct packed {
    logic [55:0]       zp;
    logic [63:0]       xp;
    logic [55:0]       zm;
    logic [63:0]       xm;
    logic signed [5:0] k;
    logic              odd;
  } hpde_lane_t;

  // Curve geometry from the configuration registers, index 0..2 is x, y, z.
  typedef struct packed {
    logic [2:0][31:0] cen;
    logic [2:0][31:0] ka;
    logic [2:0][31:0] kb;
  } hpde_geom_t;

  // floor(2^e / m) by long division; used only to build constants.
  function automatic logic [56:0] pow2_over(input int e, input int m);
    logic [56:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 56; b >= 0; b--) begin
      rem = {rem[62:0], (b == e)};
      if (rem >= 64'(m)) begin
        rem  = rem - 64'(m);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + 2^-i) in Q56 as a truncated alternating series.
  function automatic logic [55:0] ln1p_q56(input int i);
    logic signed [63:0] s;
    s = '0;
    for (int m = 1; m <= 56; m++) begin
      if (i * m <= 56) begin
        if (m[0]) s = s + 64'(pow2_over(56 - i * m, m));
        else      s = s - 64'(pow2_over(56 - i * m, m));
      end
    end
    return s[55:0];
  endfunction

  // Floor a sum in units of 2^-48 to Q32.32 and saturate to 64 bits.
  function automatic logic [63:0] sat_q32(input logic signed [97:0] t);
    logic signed [97:0] q;
    q = t >>> 16;
    if (q[97:63] == '0 || q[97:63] == '1) return q[63:0];
    else if (q[97])                        return 64'h8000_0000_0000_0000;
    else                                   return 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

endpackage

[rtl/hyperbola_point_and_derivative_eval_top.sv]
// ----------------------------------------------------------------------------
// Hyperbola point and derivative evaluator
// Point, first, second and n-th derivative of a parametric hyperbola.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge where start is high and busy is low;
//   busy stays low, so a request can be issued in every cycle. The request
//   carries u (Q5.26) and a derivative order whose parity picks the n-th form.
//   Each result appears on result for a single cycle with done high; the
//   receiver must take it then, as it cannot hold results back.
//   From request to done a request passes three range reduction stages,
//   one CORDIC cell per iteration and five stages of scaling,
//   multiplication, summing and saturation. Throughput is one request per
//   cycle, set by the fully pipelined cell chain.
//   Geometry is written through wr_en, wr_index and wr_data while no request
//   is in flight. Reset clears geometry to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module hyperbola_point_and_derivative_eval_top
  import hpde_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CordicIterDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  hpde_req_t   request,
  output logic        done,
  output hpde_res_t   result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data
);

  hpde_geom_t geom;
  logic       v [CORDIC_ITERATIONS + 1];
  hpde_lane_t lanes [CORDIC_ITERATIONS + 1];

  assign busy = 1'b0;

  // Geometry registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      geom <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER_XY: begin
          geom.cen[0] <= wr_data[31:0];
          geom.cen[1] <= wr_data[63:32];
        end
        REG_CENTER_Z: geom.cen[2] <= wr_data[31:0];
        REG_MAJOR_X:  geom.ka[0]  <= wr_data[31:0];
        REG_MAJOR_Y:  geom.ka[1]  <= wr_data[31:0];
        REG_MAJOR_Z:  geom.ka[2]  <= wr_data[31:0];
        REG_MINOR_X:  geom.kb[0]  <= wr_data[31:0];
        REG_MINOR_Y:  geom.kb[1]  <= wr_data[31:0];
        REG_MINOR_Z:  geom.kb[2]  <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  hpde_range_red u_range (
    .clk   (clk),
    .rst   (rst),
    .v_in  (start && !busy),
    .req   (request),
    .v_out (v[0]),
    .lane  (lanes[0])
  );

  // Row of exponential cells.
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
    hpde_cordic_cell #(.STEP(i + 1)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .v_in     (v[i]),
      .lane_in  (lanes[i]),
      .v_out    (v[i + 1]),
      .lane_out (lanes[i + 1])
    );
  end

  hpde_combine u_comb (
    .clk    (clk),
    .rst    (rst),
    .v_in   (v[CORDIC_ITERATIONS]),
    .lane   (lanes[CORDIC_ITERATIONS]),
    .geom   (geom),
    .done   (done),
    .result (result)
  );

  // A request leaves the chain once it has passed through every cell.
  a_chain_delay : assert property (@(posedge clk) disable iff (rst)
    (!rst) [*(CORDIC_ITERATIONS + 1)] |->
      (v[CORDIC_ITERATIONS] == $past(v[0], CORDIC_ITERATIONS)))
    else $error("cell chain lost or invented a request");

endmodule

[rtl/hpde_range_red.sv]
// ----------------------------------------------------------------------------
// Range reduction
// Splits u into k*ln2 + r with r in [0, ln2) and seeds both exponential
// lanes of the CORDIC chain. Three register stages.
// ----------------------------------------------------------------------------
module hpde_range_red
  import hpde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       v_in,
  input  hpde_req_t  req,
  output logic       v_out,
  output hpde_lane_t lane
);

  logic               v1, v2;
  logic signed [30:0] u1;
  logic signed [5:0]  k1, k2;
  logic               odd1, odd2;
  logic signed [62:0] r2;
  logic signed [47:0] est;
  logic signed [62:0] uq;
  logic signed [62:0] kl;
  logic signed [62:0] r_fix;
  logic signed [5:0]  k_fix;

  // Estimate of k from u times 1/ln2; within one of the true floor.
  assign est = req.param_u * $signed({1'b0, INV_LN2_Q16});

  // Remainder against the estimate.
  assign uq = $signed({u1, 32'd0}) >>> 2;
  assign kl = 63'(k1) * $signed({7'd0, LN2_Q56});

  // Bring the remainder into [0, ln2).
  always_comb begin
    r_fix = r2;
    k_fix = k2;
    if (r2 < 0) begin
      r_fix = r2 + $signed({7'd0, LN2_Q56});
      k_fix = k2 - 6'sd1;
    end else if (r2 >= $signed({7'd0, LN2_Q56})) begin
      r_fix = r2 - $signed({7'd0, LN2_Q56});
      k_fix = k2 + 6'sd1;
    end
  end

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v_out <= 1'b0;
    end else begin
      v1    <= v_in;
      v2    <= v1;
      v_out <= v2;
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk) begin
    u1      <= req.param_u;
    k1      <= est[47:42];
    odd1    <= req.deriv_order[0];
    r2      <= uq - kl;
    k2      <= k1;
    odd2    <= odd1;
    lane.zp <= r_fix[55:0];
    lane.zm <= LN2_Q56 - r_fix[55:0];
    lane.xp <= ONE_Q60;
    lane.xm <= ONE_Q60;
    lane.k  <= k_fix;
    lane.odd <= odd2;
  end

  // The two lane arguments always add up to ln2, and r stays below ln2.
  a_lanes_sum : assert property (@(posedge clk) disable iff (rst)
    v_out |-> (57'(lane.zp) + 57'(lane.zm) == 57'(LN2_Q56)))
    else $error("range reduction lanes do not sum to ln2");
  a_r_range : assert property (@(posedge clk) disable iff (rst)
    v_out |-> (lane.zp < LN2_Q56))
    else $error("reduced argument out of range");

endmodule

[rtl/hpde_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC exponential cell
// One step of the shift-and-add exponential on both lanes: where the
// argument covers ln(1 + 2^-STEP) it is reduced and x grows by x * 2^-STEP.
// ----------------------------------------------------------------------------
module hpde_cordic_cell
  import hpde_pkg::*;
#(
  parameter int STEP = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       v_in,
  input  hpde_lane_t lane_in,
  output logic       v_out,
  output hpde_lane_t lane_out
);

  localparam logic [55:0] T_STEP = ln1p_q56(STEP);

  hpde_lane_t lane_next;

  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else     v_out <= v_in;
  end

  // Both lanes step together; exponent and parity ride along.
  always_comb begin
    lane_next = lane_in;
    if (lane_in.zp >= T_STEP) begin
      lane_next.zp = lane_in.zp - T_STEP;
      lane_next.xp = lane_in.xp + (lane_in.xp >> STEP);
    end
    if (lane_in.zm >= T_STEP) begin
      lane_next.zm = lane_in.zm - T_STEP;
      lane_next.xm = lane_in.xm + (lane_in.xm >> STEP);
    end
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

[rtl/hpde_combine.sv]
// ----------------------------------------------------------------------------
// Vector combiner
// Scales the exponentials into cosh and sinh, forms the axis products and
// the saturated Q32.32 vectors. Five register stages.
// ----------------------------------------------------------------------------
module hpde_combine
  import hpde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       v_in,
  input  hpde_lane_t lane,
  input  hpde_geom_t geom,
  output logic       done,
  output hpde_res_t  result
);

  logic               v0, v1, v2, v3;
  logic               odd0, odd1, odd2, odd3, odd4;
  logic [63:0]        ch, sh;
  logic signed [6:0]  sp_w, sm_w;
  logic [63:0]        ea, eb;
  // Partial products, high and low halves of cosh and sinh.
  logic signed [63:0] ach_h [3], ash_h [3], bch_h [3], bsh_h [3];
  logic signed [64:0] ach_l [3], ash_l [3], bch_l [3], bsh_l [3];
  logic signed [95:0] ach [3], ash [3], bch [3], bsh [3];
  logic signed [96:0] t1 [3], t2 [3];
  logic signed [97:0] tp [3];
  logic [63:0]        pt [3], d1 [3], d2 [3];

  // Binary scaling of e^r and e^(ln2 - r).
  assign sp_w = 7'sd29 - 7'(lane.k);
  assign sm_w = 7'sd30 + 7'(lane.k);
  assign ea   = lane.xp >> sp_w[5:0];
  assign eb   = lane.xm >> sm_w[5:0];

  // Final sums with the center folded into the point, then saturation.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tp[j] = 98'(t2[j]) + 98'($signed({geom.cen[j], 32'd0}));
      pt[j] = sat_q32(tp[j]);
      d1[j] = sat_q32(98'(t1[j]));
      d2[j] = sat_q32(98'(t2[j]));
    end
  end

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= v_in;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Arithmetic pipeline.
  always_ff @(posedge clk) begin
    ch   <= ea + eb;
    sh   <= ea - eb;
    odd0 <= lane.odd;
    odd1 <= odd0;
    odd2 <= odd1;
    odd3 <= odd2;
    odd4 <= odd3;
    for (int j = 0; j < 3; j++) begin
      ach_h[j] <= $signed(geom.ka[j]) * $signed(ch[63:32]);
      ash_h[j] <= $signed(geom.ka[j]) * $signed(sh[63:32]);
      bch_h[j] <= $signed(geom.kb[j]) * $signed(ch[63:32]);
      bsh_h[j] <= $signed(geom.kb[j]) * $signed(sh[63:32]);
      ach_l[j] <= $signed(geom.ka[j]) * $signed({1'b0, ch[31:0]});
      ash_l[j] <= $signed(geom.ka[j]) * $signed({1'b0, sh[31:0]});
      bch_l[j] <= $signed(geom.kb[j]) * $signed({1'b0, ch[31:0]});
      bsh_l[j] <= $signed(geom.kb[j]) * $signed({1'b0, sh[31:0]});
      ach[j]   <= $signed({ach_h[j], 32'd0}) + 96'(ach_l[j]);
      ash[j]   <= $signed({ash_h[j], 32'd0}) + 96'(ash_l[j]);
      bch[j]   <= $signed({bch_h[j], 32'd0}) + 96'(bch_l[j]);
      bsh[j]   <= $signed({bsh_h[j], 32'd0}) + 96'(bsh_l[j]);
      t1[j]    <= 97'(ash[j]) + 97'(bch[j]);
      t2[j]    <= 97'(ach[j]) + 97'(bsh[j]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    result.point_x        <= pt[0];
    result.point_y        <= pt[1];
    result.point_z        <= pt[2];
    result.first_deriv_x  <= d1[0];
    result.first_deriv_y  <= d1[1];
    result.first_deriv_z  <= d1[2];
    result.second_deriv_x <= d2[0];
    result.second_deriv_y <= d2[1];
    result.second_deriv_z <= d2[2];
    result.nth_deriv_x    <= odd3 ? d1[0] : d2[0];
    result.nth_deriv_y    <= odd3 ? d1[1] : d2[1];
    result.nth_deriv_z    <= odd3 ? d1[2] : d2[2];
  end

  // The requested derivative follows the parity of the order.
  a_nth_sel : assert property (@(posedge clk) disable iff (rst)
    done |-> (odd4 ? (result.nth_deriv_x == result.first_deriv_x &&
                      result.nth_deriv_z == result.first_deriv_z)
                   : (result.nth_deriv_y == result.second_deriv_y &&
                      result.nth_deriv_z == result.second_deriv_z)))
    else $error("nth derivative does not match its parity");
  a_done_reset : assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");

endmodule

[dv/hyperbola_point_and_derivative_eval_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hyperbola evaluator checker
// Watches the geometry write port and the request and result channels. It
// keeps its own copy of the geometry, works out the four vectors for every
// accepted request and compares each result with the oldest expected one.
// ----------------------------------------------------------------------------
module hyperbola_point_and_derivative_eval_checker
  import hpde_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CordicIterDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  hpde_req_t   request,
  input  logic        done,
  input  hpde_res_t   result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  output int          fail_count,
  output int          pending_results
);

  localparam longint LnTwo = 64'h00B17217F7D1CF7A;

  // Geometry copy: index 0..2 is x, y, z.
  logic signed [31:0] centre [3];
  logic signed [31:0] major  [3];
  logic signed [31:0] minor  [3];

  hpde_res_t curve_results_q[$];

  // ln(1 + 2^-i) in Q56 as a truncated alternating series.
  function automatic longint log_step(input int i);
    longint s;
    longint t;
    s = 0;
    for (int m = 1; i * m <= 56; m++) begin
      t = longint'((64'd1 << (56 - i * m)) / m);
      if (m % 2 == 1) s += t;
      else            s -= t;
    end
    return s;
  endfunction

  // Shift-and-add exponential: Q56 argument, Q60 result.
  function automatic logic [63:0] exp_shift_add(input longint z);
    logic [63:0] x;
    longint      t;
    x = 64'h1000_0000_0000_0000;
    for (int i = 1; i <= CORDIC_ITERATIONS && i < 57; i++) begin
      t = log_step(i);
      if (z >= t) begin
        z -= t;
        x += x >> i;
      end
    end
    return x;
  endfunction

  // base * 2^32 + ka * ca + kb * cb, floored to Q32.32 and saturated.
  function automatic logic signed [63:0] axis_sum(input longint base, input longint ka,
                                                  input longint ca, input longint kb,
                                                  input longint cb);
    logic signed [127:0] w_base, w_ka, w_ca, w_kb, w_cb, total;
    w_base = base;
    w_ka   = ka;
    w_ca   = ca;
    w_kb   = kb;
    w_cb   = cb;
    total  = (w_base <<< 32) + w_ka * w_ca + w_kb * w_cb;
    total  = total >>> 16;
    if (total > 128'sh7FFF_FFFF_FFFF_FFFF)       return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (total < -128'sh8000_0000_0000_0000)      return 64'sh8000_0000_0000_0000;
    return total[63:0];
  endfunction

  // Full result for one request under the current geometry.
  function automatic hpde_res_t predict_curve(input hpde_req_t req);
    hpde_res_t   res;
    longint      uq, k, r, ch, sh;
    logic [63:0] ep, em, a, b;
    logic signed [63:0] pt [3];
    logic signed [63:0] d1 [3];
    logic signed [63:0] d2 [3];
    uq = longint'(req.param_u) * (64'sd1 <<< 30);
    k  = uq / LnTwo;
    if (uq % LnTwo != 0 && uq < 0) k--;
    r  = uq - k * LnTwo;
    ep = exp_shift_add(r);
    em = exp_shift_add(LnTwo - r);
    a  = ep >> (29 - k);
    b  = em >> (30 + k);
    ch = longint'(a + b);
    sh = longint'(a) - longint'(b);
    for (int j = 0; j < 3; j++) begin
      pt[j] = axis_sum(centre[j], major[j], ch, minor[j], sh);
      d1[j] = axis_sum(0, major[j], sh, minor[j], ch);
      d2[j] = axis_sum(0, major[j], ch, minor[j], sh);
    end
    res.point_x        = pt[0];
    res.point_y        = pt[1];
    res.point_z        = pt[2];
    res.first_deriv_x  = d1[0];
    res.first_deriv_y  = d1[1];
    res.first_deriv_z  = d1[2];
    res.second_deriv_x = d2[0];
    res.second_deriv_y = d2[1];
    res.second_deriv_z = d2[2];
    res.nth_deriv_x    = req.deriv_order[0] ? d1[0] : d2[0];
    res.nth_deriv_y    = req.deriv_order[0] ? d1[1] : d2[1];
    res.nth_deriv_z    = req.deriv_order[0] ? d1[2] : d2[2];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  assign pending_results = curve_results_q.size();

  // Geometry writes, request capture and result comparison.
  always @(posedge clk) begin
    hpde_res_t want;
    if (rst) begin
      for (int j = 0; j < 3; j++) begin
        centre[j] = '0;
        major[j]  = '0;
        minor[j]  = '0;
      end
      curve_results_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (curve_results_q.size() == 0) begin
          $error("result: none expected, got %h", result);
          fail_count++;
        end else begin
          want = curve_results_q.pop_front();
          check_field("point_x", want.point_x, result.point_x);
          check_field("point_y", want.point_y, result.point_y);
          check_field("point_z", want.point_z, result.point_z);
          check_field("first_deriv_x", want.first_deriv_x, result.first_deriv_x);
          check_field("first_deriv_y", want.first_deriv_y, result.first_deriv_y);
          check_field("first_deriv_z", want.first_deriv_z, result.first_deriv_z);
          check_field("second_deriv_x", want.second_deriv_x, result.second_deriv_x);
          check_field("second_deriv_y", want.second_deriv_y, result.second_deriv_y);
          check_field("second_deriv_z", want.second_deriv_z, result.second_deriv_z);
          check_field("nth_deriv_x", want.nth_deriv_x, result.nth_deriv_x);
          check_field("nth_deriv_y", want.nth_deriv_y, result.nth_deriv_y);
          check_field("nth_deriv_z", want.nth_deriv_z, result.nth_deriv_z);
        end
      end
      if (start && !busy) curve_results_q.push_back(predict_curve(request));
      if (wr_en) begin
        case (wr_index)
          REG_CENTER_XY: begin
            centre[0] = wr_data[31:0];
            centre[1] = wr_data[63:32];
          end
          REG_CENTER_Z: centre[2] = wr_data[31:0];
          REG_MAJOR_X:  major[0]  = wr_data[31:0];
          REG_MAJOR_Y:  major[1]  = wr_data[31:0];
          REG_MAJOR_Z:  major[2]  = wr_data[31:0];
          REG_MINOR_X:  minor[0]  = wr_data[31:0];
          REG_MINOR_Y:  minor[1]  = wr_data[31:0];
          REG_MINOR_Z:  minor[2]  = wr_data[31:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[dv/hyperbola_point_and_derivative_eval_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hyperbola evaluator testbench
// Drives directed and random requests through several geometry settings,
// with random gaps between requests; the checker predicts and compares.
// ----------------------------------------------------------------------------
module hyperbola_point_and_derivative_eval_top_tb;
  import hpde_pkg::*;

  localparam int Latency = 8 + CordicIterDefault;
  localparam int UMax12  = 805306368;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  hpde_req_t   request;
  logic        done;
  hpde_res_t   result;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [63:0] wr_data;
  int          fail_count;
  int          pending_results;

  hyperbola_point_and_derivative_eval_top u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  hyperbola_point_and_derivative_eval_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .request         (request),
    .done            (done),
    .result          (result),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  // Issue one request, then leave a random gap (mostly short, some long).
  task automatic send_request(input logic [30:0] u, input logic [5:0] order);
    int gap;
    request <= '{param_u: u, deriv_order: order};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: gap = 0;
      4, 5, 6:    gap = $urandom_range(1, 3);
      7, 8:       gap = $urandom_range(4, 10);
      default:    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random parameter: mostly within the nominal range, some small, some the whole field.
  function automatic logic [30:0] random_u();
    case ($urandom_range(0, 19))
      0, 1, 2: return 31'($urandom);
      3, 4, 5: return 31'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
      default: return 31'(int'($urandom_range(0, 2 * UMax12)) - UMax12);
    endcase
  endfunction

  // Wait until every expected result has come, then let the pipeline drain.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // Write the whole geometry in consecutive cycles.
  task automatic load_geometry(input logic [63:0] cxy, input logic [31:0] vals [7]);
    wr_en    <= 1'b1;
    wr_index <= REG_CENTER_XY;
    wr_data  <= cxy;
    @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      wr_index <= 3'(i + 1);
      wr_data  <= {$urandom, vals[i]};
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  initial begin
    logic [31:0] vals [7];
    logic [63:0] cxy;
    rst      = 1'b1;
    start    = 1'b0;
    request  = '0;
    wr_en    = 1'b0;
    wr_index = REG_CENTER_XY;
    wr_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Geometry as left by reset: every output is zero.
    send_request(31'd0, 6'd1);
    send_request(31'(UMax12), 6'd2);
    drain_pipeline();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          cxy = {32'h0001_0000, 32'h0002_0000};
          vals = '{32'h0000_8000, 32'h0003_0000, 32'h0000_0000, 32'hFFFF_0000,
                   32'h0000_0000, 32'h0001_0000, 32'h0002_0000};
        end
        1: begin
          cxy = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
          vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        end
        2: begin
          cxy = {32'h8000_0000, 32'h8000_0000};
          vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        end
        3: begin
          cxy = {32'h0000_0001, 32'hFFFF_FFFF};
          vals = '{32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003,
                   32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000};
        end
        default: begin
          cxy = {$urandom, $urandom};
          foreach (vals[i])
            vals[i] = ($urandom_range(0, 1) != 0) ? $urandom
                                                   : 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        end
      endcase
      load_geometry(cxy, vals);

      // Directed: zero, field extremes, nominal extremes, ln2 steps, order parity.
      if (phase == 0 || phase == 1) begin
        send_request(31'd0, 6'd0);
        send_request(31'h3FFF_FFFF, 6'd1);
        send_request(31'h4000_0000, 6'd2);
        send_request(31'(UMax12), 6'd63);
        send_request(31'(-UMax12), 6'd62);
        send_request(31'd1, 6'd3);
        send_request(31'h7FFF_FFFF, 6'd4);
        send_request(31'd46516320, 6'd5);
        send_request(31'(-46516320), 6'd6);
        send_request(31'd67108864, 6'd1);
        send_request(31'(-67108864), 6'd0);
        send_request(31'h2AAA_AAAA, 6'h2A);
        send_request(31'h5555_5555, 6'h15);
      end

      for (int n = 0; n < 310; n++)
        send_request(random_u(), 6'($urandom));
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hpde_pkg.sv
rtl/hpde_range_red.sv
rtl/hpde_cordic_cell.sv
rtl/hpde_combine.sv
rtl/hyperbola_point_and_derivative_eval_top.sv
dv/hyperbola_point_and_derivative_eval_checker.sv
dv/hyperbola_point_and_derivative_eval_top_tb.sv
